// ----- hw/rtl/skpf_pkg.sv -----
// Shared types and constants for the scalar Kalman pose fusion block.
// Used by the divider, the axis lanes and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skpf_pkg;

    localparam int AXES       = 3;
    localparam int WORD_W     = 32;
    localparam int DIFF_W     = 34;
    localparam int VAR_W      = 25;
    localparam int NOISE_W    = 24;
    localparam int GAIN_W     = 17;
    localparam int CFG_ADDR_W = 1;
    localparam int S_TDATA_W  = 2 * AXES * WORD_W;
    localparam int M_TDATA_W  = 144;

    localparam logic [VAR_W-1:0]   VAR_MAX  = {VAR_W{1'b1}};
    localparam logic [GAIN_W-1:0]  GAIN_MAX = {GAIN_W{1'b1}};

    localparam logic [NOISE_W-1:0] MEAS_NOISE_RESET = 24'd6554;
    localparam logic [NOISE_W-1:0] PROC_NOISE_RESET = 24'd655;

    localparam logic [CFG_ADDR_W-1:0] REG_MEAS_NOISE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROC_NOISE = 1'b1;

    localparam logic CMD_FUSE = 1'b0;
    localparam logic CMD_INIT = 1'b1;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic kbit;
        logic commit;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/skpf_divider.sv -----
// Restoring divider for the gain K = floor((P << FRAC_BITS) / (P + R)).
// One quotient bit per cycle; depends on skpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skpf_divider #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [skpf_pkg::VAR_W-1:0]   p,
    input  wire logic [skpf_pkg::NOISE_W-1:0] r,
    output logic                              done,
    output logic [FRAC_BITS-1:0]              quot
);
    import skpf_pkg::*;

    localparam int DIV_W = VAR_W + 1;
    localparam int REM_W = VAR_W + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [DIV_W-1:0]     divisor_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [FRAC_BITS-1:0] quot_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;

    logic [NOISE_W-1:0] r_eff;
    logic [REM_W-1:0]   shifted;
    logic [REM_W-1:0]   diff;
    logic               ge;

    assign r_eff   = (r == '0) ? NOISE_W'(1) : r;
    assign shifted = {rem_reg[REM_W-2:0], 1'b0};
    assign ge      = shifted >= REM_W'(divisor_reg);
    assign diff    = shifted - REM_W'(divisor_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(FRAC_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            divisor_reg <= DIV_W'(p) + DIV_W'(r_eff);
            rem_reg     <= REM_W'(p);
            quot_reg    <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg  <= ge ? diff : shifted;
            quot_reg <= {quot_reg[FRAC_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/skpf_lane.sv -----
// One axis lane: holds the estimate, forms enc + imu - 2*est and the
// shift-add product K*d, then rounds and saturates the new estimate.
// Depends on skpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skpf_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire skpf_pkg::lane_ctrl_t              ctrl,
    input  wire logic signed [skpf_pkg::WORD_W-1:0] enc,
    input  wire logic signed [skpf_pkg::WORD_W-1:0] imu,
    output logic signed [skpf_pkg::WORD_W-1:0]     est
);
    import skpf_pkg::*;

    localparam int ACC_W = FRAC_BITS + DIFF_W + 1;
    localparam int SUM_W = DIFF_W + 1;

    logic signed [WORD_W-1:0] est_reg;
    logic signed [DIFF_W-1:0] d_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [DIFF_W-1:0] d_next;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [DIFF_W-1:0] step_val;
    logic signed [SUM_W-1:0]  sum;
    logic signed [WORD_W-1:0] est_next;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< FRAC_BITS;
    localparam logic signed [SUM_W-1:0] WMAX = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] WMIN = -(SUM_W'(2147483647)) - SUM_W'(1);

    assign d_next   = DIFF_W'(enc) + DIFF_W'(imu) - (DIFF_W'(est_reg) <<< 1);
    assign acc_next = (acc_reg <<< 1) + (ctrl.kbit ? ACC_W'(d_reg) : ACC_W'(0));
    assign rounded  = acc_reg + HALF;
    assign step_val = $signed(rounded[ACC_W-1:FRAC_BITS+1]);
    assign sum      = SUM_W'(est_reg) + SUM_W'(step_val);

    always_comb begin
        if (sum > WMAX) begin
            est_next = WORD_W'(WMAX);
        end else if (sum < WMIN) begin
            est_next = WORD_W'(WMIN);
        end else begin
            est_next = sum[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
        end else if (ctrl.init) begin
            est_reg <= enc;
        end else if (ctrl.commit) begin
            est_reg <= est_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            d_reg   <= d_next;
            acc_reg <= '0;
        end else if (ctrl.step) begin
            acc_reg <= acc_next;
        end
    end

    assign est = est_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/scalar_kalman_pose_fusion.sv -----
// Top level of the scalar Kalman pose fusion: control sequencer, gain
// divider, three axis lanes and the variance/merge stage with output register.
// Depends on skpf_pkg, skpf_divider and skpf_lane.
//
// Channel   Dir  Handshake                  Payload
// s_        in   s_tvalid / s_tready        s_tdata pose pair, s_tuser cmd
// m_        out  m_tvalid / m_tready        m_tdata fused pose, variance, gain
// cfg_      in   cfg_wr_en                  cfg_addr, cfg_wr_data
//
// A fuse item runs the divider loop, the lanes' shift-add multiply loop,
// the variance and variance-update steps and then the output step; an
// init item goes straight to the output step. One item is in flight at a
// time; a stalled result holds the sequencer in its output step. Reset
// is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_pose_fusion #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // enc_x, enc_y, enc_heading, imu_x, imu_y, imu_heading
    input  wire logic [skpf_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // fused_x, fused_y, fused_heading, variance_out, gain_out, zero pad
    output logic [skpf_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [skpf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [skpf_pkg::NOISE_W-1:0]      cfg_wr_data
);
    import skpf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_VAR  = 3'd3;
    localparam logic [2:0] ST_VUPD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam int CNT_W  = $clog2(FRAC_BITS);
    localparam int PROD_W = FRAC_BITS + VAR_W + 1;
    localparam int VSUM_W = VAR_W + 2;
    localparam int KW     = (FRAC_BITS > GAIN_W) ? FRAC_BITS : GAIN_W;
    localparam int PAD_W  = M_TDATA_W - AXES * WORD_W - VAR_W - GAIN_W;

    localparam logic [VAR_W-1:0]   VAR_RESET = VAR_W'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};

    logic [2:0]             state_reg;
    logic [NOISE_W-1:0]     meas_noise_reg;
    logic [NOISE_W-1:0]     proc_noise_reg;
    logic [VAR_W-1:0]       var_reg;
    logic [FRAC_BITS-1:0]   gain_reg;
    logic [CNT_W-1:0]       mul_cnt_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   init_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic                   accept;
    logic                   div_done;
    logic [FRAC_BITS-1:0]   div_quot;
    lane_ctrl_t             lane_ctrl;
    logic signed [WORD_W-1:0] est_w [AXES];
    logic [FRAC_BITS:0]     one_minus_k;
    logic [PROD_W-1:0]      prod_next;
    logic [VSUM_W-1:0]      var_sum;
    logic [VAR_W-1:0]       var_next;
    logic [KW-1:0]          gain_ext;
    logic [GAIN_W-1:0]      gain_field;
    logic                   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_noise_reg <= MEAS_NOISE_RESET;
            proc_noise_reg <= PROC_NOISE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MEAS_NOISE: meas_noise_reg <= cfg_wr_data;
                REG_PROC_NOISE: proc_noise_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    skpf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && (s_tuser == CMD_FUSE)),
        .p       (var_reg),
        .r       (meas_noise_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        lane_ctrl.init   = accept && (s_tuser == CMD_INIT);
        lane_ctrl.load   = accept && (s_tuser == CMD_FUSE);
        lane_ctrl.step   = (state_reg == ST_MUL);
        lane_ctrl.kbit   = gain_reg[mul_cnt_reg];
        lane_ctrl.commit = (state_reg == ST_VAR);
    end

    for (genvar i = 0; i < AXES; i++) begin : g_lane
        skpf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .enc     ($signed(s_tdata[WORD_W*i +: WORD_W])),
            .imu     ($signed(s_tdata[WORD_W*(AXES+i) +: WORD_W])),
            .est     (est_w[i])
        );
    end

    assign one_minus_k = ONE_Q - {1'b0, gain_reg};
    assign prod_next   = PROD_W'(one_minus_k) * PROD_W'(var_reg);
    assign var_sum     = VSUM_W'(prod_reg[PROD_W-1:FRAC_BITS]) + VSUM_W'(proc_noise_reg);
    assign var_next    = (var_sum > VSUM_W'(VAR_MAX)) ? VAR_MAX : var_sum[VAR_W-1:0];
    assign gain_ext    = KW'(gain_reg);
    assign gain_field  = init_reg ? '0 :
                         (gain_ext > KW'(GAIN_MAX)) ? GAIN_MAX : gain_ext[GAIN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            var_reg      <= VAR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= (s_tuser == CMD_INIT) ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_cnt_reg == '0) begin
                        state_reg <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    state_reg <= ST_VUPD;
                end
                ST_VUPD: begin
                    var_reg   <= var_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            init_reg <= (s_tuser == CMD_INIT);
        end
        if (state_reg == ST_DIV && div_done) begin
            gain_reg    <= div_quot;
            mul_cnt_reg <= CNT_W'(FRAC_BITS - 1);
        end else if (state_reg == ST_MUL) begin
            mul_cnt_reg <= mul_cnt_reg - CNT_W'(1);
        end
        if (state_reg == ST_VAR) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, gain_field, var_reg,
                            est_w[2], est_w[1], est_w[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    a_fuse_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == CMD_FUSE)) |=> (state_reg == ST_DIV))
        else $error("fuse item did not start the divider");

    a_init_keeps_var: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == CMD_INIT)) |=> ((state_reg == ST_OUT) && $stable(var_reg)))
        else $error("init item changed the variance");

    a_out_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && m_tvalid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result left its step while the output was stalled");
`endif

endmodule

`default_nettype wire
